### sv/sgdmf_pkg.sv
// ---------------------------------------------------------------------------
// SGD matrix factorisation engine package
// Shared constants, codes and saturation helpers.
// ---------------------------------------------------------------------------
package sgdmf_pkg;

   localparam int DEF_MAX_FEATURES = 16;
   localparam int DEF_MAX_USERS    = 256;
   localparam int DEF_MAX_ITEMS    = 256;
   localparam int DEF_MAX_RATINGS  = 4096;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [1:0] {
      OP_LOAD    = 2'd0,
      OP_TRAIN   = 2'd1,
      OP_PREDICT = 2'd2
   } opcode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FEATURES_IN_USE = 3'd0,
      CSR_FEATURE_START   = 3'd1,
      CSR_LEARNING_RATE   = 3'd2,
      CSR_REGULARISATION  = 3'd3,
      CSR_MAX_EPOCHS      = 3'd4,
      CSR_MIN_EPOCHS      = 3'd5
   } csr_index_type;

   localparam logic KIND_PREDICTION = 1'b0;
   localparam logic KIND_TRAINED    = 1'b1;

   // Clamp a 24-bit signed value to the signed 16-bit range.
   function automatic logic signed [15:0] sat16(input logic signed [23:0] x);
      logic signed [15:0] r;
      if (x > 24'sd32767) begin
         r = 16'sh7FFF;
      end else if (x < -24'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = x[15:0];
      end
      return r;
   endfunction

   // Clamp a 33-bit signed value to the signed 32-bit range.
   function automatic logic signed [31:0] sat32(input logic signed [32:0] x);
      logic signed [31:0] r;
      if (x[32] != x[31]) begin
         r = x[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

endpackage

### sv/sgdmf_req_if.sv
// ---------------------------------------------------------------------------
// Request channel
// Carries load, train and predict transactions into the engine.
// ---------------------------------------------------------------------------
interface sgdmf_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         opcode;
   logic [7:0]         user_index;
   logic [7:0]         item_index;
   logic signed [15:0] rating_value;

   modport source (output valid, opcode, user_index, item_index, rating_value,
                   input ready);
   modport sink   (input valid, opcode, user_index, item_index, rating_value,
                   output ready);
endinterface

### sv/sgdmf_rsp_if.sv
// ---------------------------------------------------------------------------
// Response channel
// Carries prediction answers and training completion transactions.
// ---------------------------------------------------------------------------
interface sgdmf_rsp_if;
   logic               valid;
   logic               ready;
   logic               result_kind;
   logic signed [31:0] prediction;
   logic [31:0]        error_sum;

   modport source (output valid, result_kind, prediction, error_sum, input ready);
   modport sink   (input valid, result_kind, prediction, error_sum, output ready);
endinterface

### sv/sgd_matrix_factorisation_engine.sv
// ---------------------------------------------------------------------------
// SGD matrix factorisation engine
// Stores ratings, trains user and item factors rank by rank, answers queries.
// ---------------------------------------------------------------------------
// Usage: transactions arrive on req_ch. A load (opcode 0) writes one rating
// into the store if its indices are in range and the store is not full; it
// gives no response, and the block is ready again on the next cycle. A train
// transaction copies the loaded ratings into the residual store, sweeps every
// factor to the start value, then per rank runs epochs over the ratings, and
// after each rank copies the last errors back. A predict transaction sums the
// products of the two factors of each rank in use, or answers zero when an
// index is out of range. Steps run one after another: every product of a step
// passes through the single shared multiplier in turn, and each store has a
// single read port.
// Results leave on rsp_ch from an output register; the next request is taken
// while a response still waits, and the engine holds a finished result
// internally until the output register is free when the receiver stalls.
// Reset is synchronous, clears the rating count, state and response valid flag
// and sets the configuration defaults; factor and rating stores keep their data.
// ---------------------------------------------------------------------------
module sgd_matrix_factorisation_engine #(
   parameter int MAX_FEATURES = sgdmf_pkg::DEF_MAX_FEATURES,
   parameter int MAX_USERS    = sgdmf_pkg::DEF_MAX_USERS,
   parameter int MAX_ITEMS    = sgdmf_pkg::DEF_MAX_ITEMS,
   parameter int MAX_RATINGS  = sgdmf_pkg::DEF_MAX_RATINGS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   sgdmf_req_if.sink                            req_ch,
   sgdmf_rsp_if.source                          rsp_ch,
   input  logic                                 csr_write,
   input  logic [sgdmf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sgdmf_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import sgdmf_pkg::*;

   localparam int FW   = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
   localparam int NW   = $clog2(MAX_FEATURES + 1);
   localparam int UW   = (MAX_USERS > 1) ? $clog2(MAX_USERS) : 1;
   localparam int IW   = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int RW   = (MAX_RATINGS > 1) ? $clog2(MAX_RATINGS) : 1;
   localparam int CW   = $clog2(MAX_RATINGS + 1);
   localparam int MUI  = (MAX_USERS > MAX_ITEMS) ? MAX_USERS : MAX_ITEMS;
   localparam int MW   = (UW > IW) ? UW : IW;
   localparam int SW   = MW + FW;
   localparam int UDEP = MAX_USERS * (2 ** FW);
   localparam int IDEP = MAX_ITEMS * (2 ** FW);
   localparam int SWEEP_LAST = MUI * (2 ** FW) - 1;

   typedef enum logic [4:0] {
      S_IDLE, S_INIT_RD, S_INIT_WR, S_INIT_FACT, S_RANK_START,
      S_T_ADDR, S_T_FADDR, S_T_MUL0, S_T_ERR, S_T_M1, S_T_M2, S_T_M3, S_T_M4,
      S_T_UU, S_T_V2, S_T_V3, S_T_V4, S_T_WR, S_EPOCH, S_RANK_END,
      S_RES_RD, S_RES_WR, S_NEXT_RANK, S_P_RD, S_P_MUL, S_P_ACC, S_OUT
   } state_type;

   // Configuration registers
   logic [4:0]         fiu_ff;
   logic signed [15:0] fstart_ff;
   logic [15:0]        lrate_ff;
   logic [15:0]        reg_ff;
   logic [9:0]         maxep_ff;
   logic [9:0]         minep_ff;

   // Stores
   logic [UW-1:0]      rating_users [MAX_RATINGS];
   logic [IW-1:0]      rating_items [MAX_RATINGS];
   logic signed [15:0] loaded_mem   [MAX_RATINGS];
   logic signed [15:0] residual_mem [MAX_RATINGS];
   logic signed [15:0] lasterr_mem  [MAX_RATINGS];
   logic signed [15:0] ufact_mem    [UDEP];
   logic signed [15:0] ifact_mem    [IDEP];

   // Store read data
   logic [UW-1:0]      ru_q;
   logic [IW-1:0]      ri_q;
   logic signed [15:0] res_q;
   logic signed [15:0] loaded_q;
   logic signed [15:0] lasterr_q;
   logic signed [15:0] uf_q;
   logic signed [15:0] vf_q;

   // Sequencer state
   state_type          state_ff;
   logic [CW-1:0]      count_ff;
   logic [CW-1:0]      idx_ff;
   logic [SW-1:0]      sweep_ff;
   logic [NW-1:0]      rank_ff;
   logic [9:0]         epoch_ff;
   logic [31:0]        h0_ff, h1_ff, h2_ff;
   logic [31:0]        last_ff;
   logic [31:0]        final_ff;
   logic               ran_ff;
   logic [UW-1:0]      pu_ff;
   logic [IW-1:0]      pv_ff;
   logic signed [15:0] err_ff;
   logic signed [15:0] newu_ff;
   logic signed [36:0] tmp_ff;
   logic signed [36:0] grad_ff;
   logic signed [53:0] prod_ff;
   logic signed [31:0] acc_ff;

   // Pending and output result
   logic               pend_kind_ff;
   logic signed [31:0] pend_pred_ff;
   logic [31:0]        pend_sum_ff;
   logic               rsp_valid_ff;
   logic               rsp_kind_ff;
   logic signed [31:0] rsp_pred_ff;
   logic [31:0]        rsp_sum_ff;

   // Combinational helpers
   logic [NW-1:0]      nf;
   logic [31:0]        nf_wide;
   logic [31:0]        req_u32, req_v32;
   logic               req_in_range;
   logic signed [36:0] mul_a;
   logic signed [16:0] mul_b;
   logic signed [53:0] mul_p;
   logic signed [33:0] err24;
   logic signed [33:0] err_rnd;
   logic signed [15:0] err_in;
   logic [16:0]        err_mag;
   logic [32:0]        sum_wide;
   logic [31:0]        sum_in;
   logic signed [53:0] upd_rnd;
   logic signed [23:0] upd_sum;
   logic signed [15:0] old_f;
   logic signed [15:0] upd_in;
   logic signed [31:0] acc_in;
   logic [UW+FW-1:0]   uf_addr;
   logic [IW+FW-1:0]   vf_addr;
   logic               stop_early;
   logic               accept;

   assign accept       = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == S_IDLE);

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.result_kind = rsp_kind_ff;
   assign rsp_ch.prediction  = rsp_pred_ff;
   assign rsp_ch.error_sum   = rsp_sum_ff;

   // Ranks in use: the register is clamped to the number of stored ranks.
   always_comb begin
      if (32'(fiu_ff) > MAX_FEATURES) begin
         nf_wide = 32'(MAX_FEATURES);
      end else begin
         nf_wide = 32'(fiu_ff);
      end
      nf = nf_wide[NW-1:0];
   end

   assign req_u32      = {24'd0, req_ch.user_index};
   assign req_v32      = {24'd0, req_ch.item_index};
   assign req_in_range = (req_u32 < 32'(MAX_USERS)) && (req_v32 < 32'(MAX_ITEMS));

   // Factor addresses: user or item index above the rank.
   always_comb begin
      if (state_ff == S_P_RD) begin
         uf_addr = {pu_ff, rank_ff[FW-1:0]};
         vf_addr = {pv_ff, rank_ff[FW-1:0]};
      end else begin
         uf_addr = {ru_q, rank_ff[FW-1:0]};
         vf_addr = {ri_q, rank_ff[FW-1:0]};
      end
   end

   // The shared multiplier: operands are chosen by the sequencer step.
   always_comb begin
      case (state_ff)
         S_T_M1: begin
            mul_a = 37'(err_ff);
            mul_b = 17'(vf_q);
         end
         S_T_M2: begin
            mul_a = 37'(uf_q);
            mul_b = $signed({1'b0, reg_ff});
         end
         S_T_M4, S_T_V4: begin
            mul_a = grad_ff;
            mul_b = $signed({1'b0, lrate_ff});
         end
         S_T_UU: begin
            mul_a = 37'(err_ff);
            mul_b = 17'(uf_q);
         end
         S_T_V2: begin
            mul_a = 37'(vf_q);
            mul_b = $signed({1'b0, reg_ff});
         end
         default: begin
            mul_a = 37'(uf_q);
            mul_b = 17'(vf_q);
         end
      endcase
      mul_p = mul_a * mul_b;
   end

   // Error of one step, rounded half up and saturated to Q4.12.
   always_comb begin
      err24   = $signed({{6{res_q[15]}}, res_q, 12'd0}) - 34'($signed(prod_ff[32:0]));
      err_rnd = (err24 + 34'sd2048) >>> 12;
      err_in  = sat16(err_rnd[23:0]);
      err_mag = err_in[15] ? 17'(-18'(err_in)) : 17'(err_in);
      sum_wide = {1'b0, h0_ff} + 33'(err_mag);
      sum_in   = sum_wide[32] ? 32'hFFFF_FFFF : sum_wide[31:0];
   end

   // Factor update: old value plus the rounded scaled gradient, saturated.
   always_comb begin
      old_f   = (state_ff == S_T_WR) ? vf_q : uf_q;
      upd_rnd = (prod_ff + 54'sh0_0000_8000_0000) >>> 32;
      upd_sum = 24'(old_f) + upd_rnd[23:0];
      upd_in  = sat16(upd_sum);
   end

   assign acc_in = sat32(33'(acc_ff) + 33'($signed(prod_ff[31:0])));

   // Early stop: past the minimum epochs, after the error sum rose and fell.
   assign stop_early = (epoch_ff > minep_ff) && (h0_ff < h1_ff) && (h1_ff > h2_ff);

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         fiu_ff    <= 5'd16;
         fstart_ff <= 16'sd410;
         lrate_ff  <= 16'd66;
         reg_ff    <= 16'd1311;
         maxep_ff  <= 10'd200;
         minep_ff  <= 10'd50;
      end else if (csr_write) begin
         case (csr_index)
            CSR_FEATURES_IN_USE: fiu_ff    <= csr_wdata[4:0];
            CSR_FEATURE_START:   fstart_ff <= $signed(csr_wdata);
            CSR_LEARNING_RATE:   lrate_ff  <= csr_wdata;
            CSR_REGULARISATION:  reg_ff    <= csr_wdata;
            CSR_MAX_EPOCHS:      maxep_ff  <= csr_wdata[9:0];
            CSR_MIN_EPOCHS:      minep_ff  <= csr_wdata[9:0];
            default: begin
            end
         endcase
      end
   end

   // Rating stores: written on load; indices read once per training step, ratings once per copy.
   always_ff @(posedge clock) begin
      if (accept && (req_ch.opcode == OP_LOAD) && req_in_range &&
          (32'(count_ff) < 32'(MAX_RATINGS))) begin
         rating_users[count_ff[RW-1:0]] <= req_u32[UW-1:0];
         rating_items[count_ff[RW-1:0]] <= req_v32[IW-1:0];
         loaded_mem[count_ff[RW-1:0]]   <= req_ch.rating_value;
      end
      if (state_ff == S_T_ADDR) begin
         ru_q <= rating_users[idx_ff[RW-1:0]];
         ri_q <= rating_items[idx_ff[RW-1:0]];
      end
      if (state_ff == S_INIT_RD) begin
         loaded_q <= loaded_mem[idx_ff[RW-1:0]];
      end
   end

   // Residual and last-error stores
   always_ff @(posedge clock) begin
      if (state_ff == S_INIT_WR) begin
         residual_mem[idx_ff[RW-1:0]] <= loaded_q;
      end else if (state_ff == S_RES_WR) begin
         residual_mem[idx_ff[RW-1:0]] <= lasterr_q;
      end
      if (state_ff == S_T_ADDR) begin
         res_q <= residual_mem[idx_ff[RW-1:0]];
      end
      if (state_ff == S_T_ERR) begin
         lasterr_mem[idx_ff[RW-1:0]] <= err_in;
      end
      if (state_ff == S_RES_RD) begin
         lasterr_q <= lasterr_mem[idx_ff[RW-1:0]];
      end
   end

   // Factor stores
   always_ff @(posedge clock) begin
      if (state_ff == S_INIT_FACT) begin
         if (32'(sweep_ff[SW-1:FW]) < 32'(MAX_USERS)) begin
            ufact_mem[sweep_ff[UW+FW-1:0]] <= fstart_ff;
         end
         if (32'(sweep_ff[SW-1:FW]) < 32'(MAX_ITEMS)) begin
            ifact_mem[sweep_ff[IW+FW-1:0]] <= fstart_ff;
         end
      end else if (state_ff == S_T_WR) begin
         ufact_mem[uf_addr] <= newu_ff;
         ifact_mem[vf_addr] <= upd_in;
      end
      if ((state_ff == S_T_FADDR) || (state_ff == S_P_RD)) begin
         uf_q <= ufact_mem[uf_addr];
         vf_q <= ifact_mem[vf_addr];
      end
   end

   // Sequencer and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ch.ready && (state_ff != S_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  case (req_ch.opcode)
                     OP_LOAD: begin
                        if (req_in_range && (32'(count_ff) < 32'(MAX_RATINGS))) begin
                           count_ff <= count_ff + 1'b1;
                        end
                     end
                     OP_TRAIN: begin
                        idx_ff   <= '0;
                        sweep_ff <= '0;
                        final_ff <= '0;
                        rank_ff  <= '0;
                        state_ff <= (count_ff == '0) ? S_INIT_FACT : S_INIT_RD;
                     end
                     OP_PREDICT: begin
                        pu_ff   <= req_u32[UW-1:0];
                        pv_ff   <= req_v32[IW-1:0];
                        rank_ff <= '0;
                        acc_ff  <= '0;
                        if (!req_in_range || (nf == '0)) begin
                           pend_kind_ff <= KIND_PREDICTION;
                           pend_pred_ff <= '0;
                           pend_sum_ff  <= '0;
                           state_ff     <= S_OUT;
                        end else begin
                           state_ff <= S_P_RD;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            S_INIT_RD: state_ff <= S_INIT_WR;
            S_INIT_WR: begin
               idx_ff   <= idx_ff + 1'b1;
               state_ff <= (idx_ff + 1'b1 == count_ff) ? S_INIT_FACT : S_INIT_RD;
            end
            S_INIT_FACT: begin
               sweep_ff <= sweep_ff + 1'b1;
               if (32'(sweep_ff) == SWEEP_LAST) begin
                  if (nf == '0) begin
                     pend_kind_ff <= KIND_TRAINED;
                     pend_pred_ff <= '0;
                     pend_sum_ff  <= '0;
                     state_ff     <= S_OUT;
                  end else begin
                     state_ff <= S_RANK_START;
                  end
               end
            end
            S_RANK_START: begin
               h0_ff    <= '0;
               h1_ff    <= '1;
               h2_ff    <= '1;
               epoch_ff <= '0;
               ran_ff   <= 1'b0;
               idx_ff   <= '0;
               if (maxep_ff == '0) begin
                  state_ff <= S_RANK_END;
               end else begin
                  state_ff <= (count_ff == '0) ? S_EPOCH : S_T_ADDR;
               end
            end
            S_T_ADDR:  state_ff <= S_T_FADDR;
            S_T_FADDR: state_ff <= S_T_MUL0;
            S_T_MUL0: begin
               prod_ff  <= mul_p;
               state_ff <= S_T_ERR;
            end
            S_T_ERR: begin
               err_ff   <= err_in;
               h0_ff    <= sum_in;
               state_ff <= S_T_M1;
            end
            S_T_M1: begin
               prod_ff  <= mul_p;
               state_ff <= S_T_M2;
            end
            S_T_M2: begin
               tmp_ff   <= 37'($signed(prod_ff[31:0])) <<< 4;
               prod_ff  <= mul_p;
               state_ff <= S_T_M3;
            end
            S_T_M3: begin
               grad_ff  <= tmp_ff - 37'($signed(prod_ff[32:0]));
               state_ff <= S_T_M4;
            end
            S_T_M4: begin
               prod_ff  <= mul_p;
               state_ff <= S_T_UU;
            end
            S_T_UU: begin
               newu_ff  <= upd_in;
               prod_ff  <= mul_p;
               state_ff <= S_T_V2;
            end
            S_T_V2: begin
               tmp_ff   <= 37'($signed(prod_ff[31:0])) <<< 4;
               prod_ff  <= mul_p;
               state_ff <= S_T_V3;
            end
            S_T_V3: begin
               grad_ff  <= tmp_ff - 37'($signed(prod_ff[32:0]));
               state_ff <= S_T_V4;
            end
            S_T_V4: begin
               prod_ff  <= mul_p;
               state_ff <= S_T_WR;
            end
            S_T_WR: begin
               idx_ff   <= idx_ff + 1'b1;
               state_ff <= (idx_ff + 1'b1 == count_ff) ? S_EPOCH : S_T_ADDR;
            end
            S_EPOCH: begin
               ran_ff  <= 1'b1;
               last_ff <= h0_ff;
               idx_ff  <= '0;
               if (stop_early) begin
                  state_ff <= S_RANK_END;
               end else begin
                  h2_ff <= h1_ff;
                  h1_ff <= h0_ff;
                  h0_ff <= '0;
                  if ((11'(epoch_ff) + 11'd1) < 11'(maxep_ff)) begin
                     epoch_ff <= epoch_ff + 1'b1;
                     state_ff <= (count_ff == '0) ? S_EPOCH : S_T_ADDR;
                  end else begin
                     state_ff <= S_RANK_END;
                  end
               end
            end
            S_RANK_END: begin
               final_ff <= ran_ff ? last_ff : 32'd0;
               idx_ff   <= '0;
               state_ff <= (ran_ff && (count_ff != '0)) ? S_RES_RD : S_NEXT_RANK;
            end
            S_RES_RD: state_ff <= S_RES_WR;
            S_RES_WR: begin
               idx_ff   <= idx_ff + 1'b1;
               state_ff <= (idx_ff + 1'b1 == count_ff) ? S_NEXT_RANK : S_RES_RD;
            end
            S_NEXT_RANK: begin
               if (rank_ff + 1'b1 < nf) begin
                  rank_ff  <= rank_ff + 1'b1;
                  state_ff <= S_RANK_START;
               end else begin
                  pend_kind_ff <= KIND_TRAINED;
                  pend_pred_ff <= '0;
                  pend_sum_ff  <= final_ff;
                  state_ff     <= S_OUT;
               end
            end
            S_P_RD: state_ff <= S_P_MUL;
            S_P_MUL: begin
               prod_ff  <= mul_p;
               state_ff <= S_P_ACC;
            end
            S_P_ACC: begin
               acc_ff <= acc_in;
               if (rank_ff + 1'b1 < nf) begin
                  rank_ff  <= rank_ff + 1'b1;
                  state_ff <= S_P_RD;
               end else begin
                  pend_kind_ff <= KIND_PREDICTION;
                  pend_pred_ff <= acc_in;
                  pend_sum_ff  <= '0;
                  state_ff     <= S_OUT;
               end
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_ch.ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_kind_ff  <= pend_kind_ff;
                  rsp_pred_ff  <= pend_pred_ff;
                  rsp_sum_ff   <= pend_sum_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

### sv/sgdmf_checker.sv
// ---------------------------------------------------------------------------
// SGD matrix factorisation engine checker
// Port-level properties of the engine, bound to the top level.
// ---------------------------------------------------------------------------
module sgdmf_assertions (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [1:0]  req_opcode,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_kind,
   input logic [31:0] rsp_pred,
   input logic [31:0] rsp_sum
);
   import sgdmf_pkg::*;

   // A stalled response transaction stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // Reset leaves no response offered.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response offered after reset");

   // Each response kind carries zero in the field of the other kind.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_PREDICTION) |-> rsp_sum == 32'd0)
      else $error("prediction response with non-zero error sum");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_TRAINED) |-> rsp_pred == 32'd0)
      else $error("training response with non-zero prediction");

   // A load transaction produces no response of its own.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_opcode == OP_LOAD) && !rsp_valid |=> !rsp_valid)
      else $error("response after a load transaction");

endmodule

bind sgd_matrix_factorisation_engine sgdmf_assertions u_sgdmf_assertions (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .req_opcode (req_ch.opcode),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_kind   (rsp_ch.result_kind),
   .rsp_pred   (rsp_ch.prediction),
   .rsp_sum    (rsp_ch.error_sum)
);
